### sv/sht_pkg.sv
// Shared types and constants for the source health tracker.
package sht_pkg;

  typedef enum logic [2:0] {
    CMD_SAMPLE   = 3'd0,
    CMD_MISS     = 3'd1,
    CMD_LEASE    = 3'd2,
    CMD_QOS      = 3'd3,
    CMD_MATCH    = 3'd4,
    CMD_TICK     = 3'd5,
    CMD_SNAPSHOT = 3'd6,
    CMD_UNKNOWN  = 3'd7
  } cmd_e;

  localparam logic [1:0] LVL_HEALTHY  = 2'd0;
  localparam logic [1:0] LVL_DEGRADED = 2'd1;
  localparam logic [1:0] LVL_LOST     = 2'd2;

  localparam logic [2:0] RSN_NONE       = 3'd0;
  localparam logic [2:0] RSN_STALE      = 3'd1;
  localparam logic [2:0] RSN_RECOVERING = 3'd2;
  localparam logic [2:0] RSN_DEADLINE   = 3'd3;
  localparam logic [2:0] RSN_LEASE      = 3'd4;
  localparam logic [2:0] RSN_QOS        = 3'd5;
  localparam logic [2:0] RSN_UNMATCHED  = 3'd6;
  localparam logic [2:0] RSN_NODATA     = 3'd7;

  localparam logic [1:0] REG_DEGRADED_MS = 2'd0;
  localparam logic [1:0] REG_LOST_MS     = 2'd1;
  localparam logic [1:0] REG_MISSES      = 2'd2;
  localparam logic [1:0] REG_FRESH       = 2'd3;

  // One million is 64 times 15625. After a shift by six, the division by
  // 15625 is a multiplication by this reciprocal scaled by 2**71, rounded up.
  localparam logic [57:0] MS_RECIP = 58'(((128'd1 << 71) + 128'd15624) / 128'd15625);
  localparam logic [1:0]  DIV_LAST = 2'd3;

  typedef struct packed {
    logic        ever;
    logic [1:0]  level;
    logic [2:0]  reason;
    logic [62:0] last;
    logic [7:0]  fresh;
    logic [7:0]  miss;
    logic [31:0] misses;
    logic [31:0] leases;
    logic [31:0] qos;
    logic        matched;
  } entry_t;

  localparam entry_t ENTRY_RESET = '{
    ever: 1'b0, level: LVL_LOST, reason: RSN_NODATA, last: '0, fresh: '0,
    miss: '0, misses: '0, leases: '0, qos: '0, matched: 1'b0};

  typedef struct packed {
    logic capture;
    logic update;
    logic div_start;
    logic div_step;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic report;
    logic div_last;
    logic out_free;
  } ctrl_sts_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_EXEC = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_DONE = 4'b1000
  } state_e;

endpackage

### sv/sht_ctrl.sv
// Controller state machine sequencing table access, age division and reporting.
module sht_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  sht_pkg::ctrl_sts_t sts_i,
  output sht_pkg::ctrl_cmd_t cmd_o
);
  import sht_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
        if (in_valid_i) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (sts_i.report) begin
          cmd_o.div_start = 1'b1;
          state_d         = ST_DIV;
        end else begin
          cmd_o.update = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

### sv/sht_datapath.sv
// Datapath: health table, configuration, event update, age divider and result register.
module sht_datapath #(
  parameter int SOURCES = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  input  logic [2:0]         cmd_i,
  input  logic [3:0]         source_index_i,
  input  logic [62:0]        now_time_ns_i,
  input  logic [31:0]        sample_age_ms_i,
  input  logic               matched_flag_i,
  input  sht_pkg::ctrl_cmd_t ctl_i,
  output sht_pkg::ctrl_sts_t sts_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         out_level_o,
  output logic [2:0]         out_reason_o,
  output logic [62:0]        out_last_sample_time_o,
  output logic signed [44:0] out_age_ms_o,
  output logic [31:0]        out_deadline_misses_o,
  output logic [31:0]        out_lease_losses_o,
  output logic [31:0]        out_qos_events_o,
  output logic               out_writer_matched_o,
  output logic               out_source_known_o
);
  import sht_pkg::*;

  localparam int IW = (SOURCES > 1) ? $clog2(SOURCES) : 1;

  logic [31:0] deg_ms_q, lost_ms_q;
  logic [7:0]  misses_q, fresh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deg_ms_q  <= 32'd100;
      lost_ms_q <= 32'd1000;
      misses_q  <= 8'd2;
      fresh_q   <= 8'd3;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_DEGRADED_MS: deg_ms_q  <= cfg_data_i;
        REG_LOST_MS:     lost_ms_q <= cfg_data_i;
        REG_MISSES:      misses_q  <= cfg_data_i[7:0];
        REG_FRESH:       fresh_q   <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  logic [IW-1:0] idx_in;
  logic [IW-1:0] idx_q;
  logic [2:0]    cmd_q;
  logic [62:0]   now_q;
  logic [31:0]   age_in_q;
  logic          matched_q;
  logic          pres_q;

  assign idx_in = IW'(32'(source_index_i) % SOURCES);

  always_ff @(posedge clk_i) begin
    if (ctl_i.capture) begin
      idx_q     <= idx_in;
      cmd_q     <= cmd_i;
      now_q     <= now_time_ns_i;
      age_in_q  <= sample_age_ms_i;
      matched_q <= matched_flag_i;
    end
  end

  entry_t        mem [SOURCES];
  entry_t        rd_q;
  entry_t        wdata;
  logic          we;
  logic [SOURCES-1:0] present_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.capture) begin
      rd_q <= mem[idx_in];
    end
    if (we) begin
      mem[idx_q] <= wdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q <= '0;
      pres_q    <= 1'b0;
    end else begin
      if (ctl_i.capture) begin
        pres_q <= present_q[idx_in];
      end
      if (we) begin
        present_q[idx_q] <= 1'b1;
      end
    end
  end

  entry_t e;
  assign e = pres_q ? rd_q : ENTRY_RESET;

  // Event update for the commands that produce no result.
  entry_t upd;
  logic   upd_valid;
  always_comb begin
    upd       = e;
    upd_valid = 1'b1;
    unique case (cmd_q)
      CMD_SAMPLE: begin
        upd.last = now_q;
        upd.miss = '0;
        if (age_in_q > deg_ms_q) begin
          upd.fresh = '0;
          upd.ever  = 1'b1;
          if (e.level == LVL_HEALTHY) begin
            upd.level = LVL_DEGRADED;
          end
          if (upd.level != LVL_LOST) begin
            upd.reason = RSN_STALE;
          end
        end else begin
          if (e.fresh < fresh_q) begin
            upd.fresh = e.fresh + 8'd1;
          end
          if (!e.ever) begin
            upd.ever   = 1'b1;
            upd.level  = LVL_HEALTHY;
            upd.reason = RSN_NONE;
          end else if (e.level == LVL_HEALTHY) begin
            upd.reason = RSN_NONE;
          end else if (upd.fresh >= fresh_q) begin
            upd.level  = LVL_HEALTHY;
            upd.reason = RSN_NONE;
          end else begin
            upd.reason = RSN_RECOVERING;
          end
        end
      end
      CMD_MISS: begin
        if (e.misses != '1) begin
          upd.misses = e.misses + 32'd1;
        end
        if (e.miss != '1) begin
          upd.miss = e.miss + 8'd1;
        end
        upd.fresh = '0;
        if (upd.miss >= misses_q && e.level == LVL_HEALTHY) begin
          upd.level  = LVL_DEGRADED;
          upd.reason = RSN_DEADLINE;
        end
      end
      CMD_LEASE: begin
        if (e.leases != '1) begin
          upd.leases = e.leases + 32'd1;
        end
        upd.fresh  = '0;
        upd.level  = LVL_LOST;
        upd.reason = RSN_LEASE;
      end
      CMD_QOS: begin
        if (e.qos != '1) begin
          upd.qos = e.qos + 32'd1;
        end
        upd.level  = LVL_DEGRADED;
        upd.reason = RSN_QOS;
      end
      CMD_MATCH: begin
        upd.matched = matched_q;
        if (!matched_q) begin
          upd.fresh  = '0;
          upd.level  = LVL_LOST;
          upd.reason = RSN_UNMATCHED;
        end
      end
      default: upd_valid = 1'b0;
    endcase
  end

  assign sts_o.report = (cmd_q == CMD_TICK) || (cmd_q == CMD_SNAPSHOT);

  // Age in milliseconds: the magnitude is shifted down by six and then
  // multiplied by the scaled reciprocal of 15625, which is exact for every
  // 57-bit operand. The 57 by 58 bit product is summed from four 32 by 32 bit
  // partial products, one per cycle.
  logic [63:0]  diff;
  logic [62:0]  mag;
  logic         neg_q;
  logic [56:0]  dvd_q;
  logic [114:0] acc_q;
  logic [1:0]   cnt_q;
  logic [31:0]  mul_a, mul_b;
  logic [63:0]  prod;
  logic [114:0] prod_sh;

  assign diff   = {1'b0, now_q} - {1'b0, e.last};
  assign mag    = diff[63] ? 63'(-diff) : diff[62:0];
  assign prod   = {32'd0, mul_a} * {32'd0, mul_b};
  assign sts_o.div_last = (cnt_q == DIV_LAST);

  always_comb begin
    unique case (cnt_q)
      2'd0: begin
        mul_a = dvd_q[31:0];
        mul_b = MS_RECIP[31:0];
      end
      2'd1: begin
        mul_a = dvd_q[31:0];
        mul_b = {6'd0, MS_RECIP[57:32]};
      end
      2'd2: begin
        mul_a = {7'd0, dvd_q[56:32]};
        mul_b = MS_RECIP[31:0];
      end
      2'd3: begin
        mul_a = {7'd0, dvd_q[56:32]};
        mul_b = {6'd0, MS_RECIP[57:32]};
      end
    endcase
  end

  always_comb begin
    unique case (cnt_q)
      2'd0:       prod_sh = {51'd0, prod};
      2'd1, 2'd2: prod_sh = {19'd0, prod, 32'd0};
      2'd3:       prod_sh = {prod[50:0], 64'd0};
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.div_start) begin
      neg_q <= diff[63];
      dvd_q <= mag[62:6];
      acc_q <= '0;
      cnt_q <= '0;
    end else if (ctl_i.div_step) begin
      acc_q <= acc_q + prod_sh;
      cnt_q <= cnt_q + 2'd1;
    end
  end

  // Ageing judgment on the divided age.
  logic [44:0] quo;
  logic        nodata, lost_hit, deg_hit;
  logic [1:0]  j_level;
  logic [2:0]  j_reason;
  logic signed [44:0] j_age;
  entry_t      tick_e;

  assign quo      = {1'b0, acc_q[114:71]};
  assign nodata   = !e.ever || (e.last == '0);
  assign lost_hit = !neg_q && (quo >= {13'd0, lost_ms_q});
  assign deg_hit  = !neg_q && (quo >= {13'd0, deg_ms_q});

  always_comb begin
    j_level  = e.level;
    j_reason = e.reason;
    j_age    = neg_q ? -$signed(quo) : $signed(quo);
    if (nodata) begin
      j_level  = LVL_LOST;
      j_reason = RSN_NODATA;
      j_age    = '0;
    end else if (lost_hit) begin
      j_level = LVL_LOST;
      if (e.reason != RSN_LEASE && e.reason != RSN_UNMATCHED) begin
        j_reason = RSN_NODATA;
      end
    end else if (deg_hit && e.level == LVL_HEALTHY) begin
      j_level  = LVL_DEGRADED;
      j_reason = RSN_STALE;
    end
    tick_e        = e;
    tick_e.level  = j_level;
    tick_e.reason = j_reason;
    if (j_level != e.level) begin
      tick_e.fresh = '0;
    end
  end

  assign we    = (ctl_i.update && upd_valid) || (ctl_i.finish && cmd_q == CMD_TICK);
  assign wdata = ctl_i.finish ? tick_e : upd;

  // Result register.
  logic out_valid_q;
  logic known;
  assign known          = pres_q || (cmd_q == CMD_TICK);
  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o    = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.finish) begin
      if (known) begin
        out_level_o            <= j_level;
        out_reason_o           <= j_reason;
        out_last_sample_time_o <= e.last;
        out_age_ms_o           <= j_age;
        out_deadline_misses_o  <= e.misses;
        out_lease_losses_o     <= e.leases;
        out_qos_events_o       <= e.qos;
        out_writer_matched_o   <= e.matched;
        out_source_known_o     <= 1'b1;
      end else begin
        out_level_o            <= '0;
        out_reason_o           <= '0;
        out_last_sample_time_o <= '0;
        out_age_ms_o           <= '0;
        out_deadline_misses_o  <= '0;
        out_lease_losses_o     <= '0;
        out_qos_events_o       <= '0;
        out_writer_matched_o   <= 1'b0;
        out_source_known_o     <= 1'b0;
      end
    end
  end

endmodule

### sv/source_health_tracker.sv
// Top level of the source health tracker.
// The block keeps one health entry per source and handles one event transfer
// at a time. Sample, deadline miss, lease loss, QoS and match change events
// read the table entry and then write it back. Tick and snapshot events go
// through the entry read, a step that decodes the command and loads the age
// magnitude, four steps that turn the nanosecond age into milliseconds by a
// multiplication with a scaled reciprocal, one partial product per cycle,
// and a final step that judges the level, writes back (tick only) and loads
// the result register. The next event transfer is taken as soon as the block
// is back in idle, even while a result still waits in the output register;
// a report finishing while the previous result is still pending waits for
// it to be taken. An unknown command is taken and dropped. Source indexes
// wrap modulo SOURCES.
// Configuration writes are always ready and should only be issued while the
// block is idle.
module source_health_tracker #(
  parameter int SOURCES = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [2:0]         cmd_i,
  input  logic [3:0]         source_index_i,
  input  logic [62:0]        now_time_ns_i,
  input  logic [31:0]        sample_age_ms_i,
  input  logic               matched_flag_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         out_level_o,
  output logic [2:0]         out_reason_o,
  output logic [62:0]        out_last_sample_time_o,
  output logic signed [44:0] out_age_ms_o,
  output logic [31:0]        out_deadline_misses_o,
  output logic [31:0]        out_lease_losses_o,
  output logic [31:0]        out_qos_events_o,
  output logic               out_writer_matched_o,
  output logic               out_source_known_o
);
  import sht_pkg::*;

  ctrl_cmd_t ctl;
  ctrl_sts_t sts;

  // Registers are plain flops, so a configuration transfer never stalls.
  assign cfg_ready_o = 1'b1;

  sht_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (ctl)
  );

  sht_datapath #(
    .SOURCES (SOURCES)
  ) u_datapath (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .cfg_valid_i            (cfg_valid_i),
    .cfg_index_i            (cfg_index_i),
    .cfg_data_i             (cfg_data_i),
    .cmd_i                  (cmd_i),
    .source_index_i         (source_index_i),
    .now_time_ns_i          (now_time_ns_i),
    .sample_age_ms_i        (sample_age_ms_i),
    .matched_flag_i         (matched_flag_i),
    .ctl_i                  (ctl),
    .sts_o                  (sts),
    .out_valid_o            (out_valid_o),
    .out_ready_i            (out_ready_i),
    .out_level_o            (out_level_o),
    .out_reason_o           (out_reason_o),
    .out_last_sample_time_o (out_last_sample_time_o),
    .out_age_ms_o           (out_age_ms_o),
    .out_deadline_misses_o  (out_deadline_misses_o),
    .out_lease_losses_o     (out_lease_losses_o),
    .out_qos_events_o       (out_qos_events_o),
    .out_writer_matched_o   (out_writer_matched_o),
    .out_source_known_o     (out_source_known_o)
  );

`ifndef NO_ASSERTIONS
  // Only one event is in flight: an input transfer closes the input side.
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input accepted while an event is in flight");

  // An unknown source reports all zeros.
  a_unknown_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_source_known_o) |->
      (out_level_o == LVL_HEALTHY && out_reason_o == RSN_NONE &&
       out_age_ms_o == '0 && out_deadline_misses_o == '0))
    else $error("snapshot of unknown source is not zero");

  // A report with no usable sample carries a zero age and the no data reason.
  a_nodata_age: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_source_known_o && out_last_sample_time_o == '0) |->
      (out_age_ms_o == '0 && out_level_o == LVL_LOST && out_reason_o == RSN_NODATA))
    else $error("report without sample has age or wrong reason");
`endif

endmodule

### dv/source_health_tracker_tb.sv
// Self-checking testbench for the source health tracker.
module source_health_tracker_tb;
  import sht_pkg::*;

  // One event as it goes into the block.
  typedef struct {
    logic [2:0]  cmd;
    logic [3:0]  src;
    logic [62:0] now;
    logic [31:0] age;
    logic        matched;
  } event_t;

  // One health report as it should come out of the block.
  typedef struct {
    logic [1:0]  level;
    logic [2:0]  reason;
    logic [62:0] last;
    logic [44:0] age_ms;
    logic [31:0] misses;
    logic [31:0] leases;
    logic [31:0] qos;
    logic        matched;
    logic        known;
  } report_t;

  localparam int NSRC = 16;
  localparam int WATCHDOG_LIMIT = 4000;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [1:0]         cfg_index_i = '0;
  logic [31:0]        cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [2:0]         cmd_i = '0;
  logic [3:0]         source_index_i = '0;
  logic [62:0]        now_time_ns_i = '0;
  logic [31:0]        sample_age_ms_i = '0;
  logic               matched_flag_i = 1'b0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [1:0]         out_level_o;
  logic [2:0]         out_reason_o;
  logic [62:0]        out_last_sample_time_o;
  logic signed [44:0] out_age_ms_o;
  logic [31:0]        out_deadline_misses_o;
  logic [31:0]        out_lease_losses_o;
  logic [31:0]        out_qos_events_o;
  logic               out_writer_matched_o;
  logic               out_source_known_o;

  source_health_tracker #(.SOURCES(NSRC)) DUT (.*);

  // Shadow copy of the health table and of the threshold registers.
  entry_t      table_shadow [NSRC];
  logic        present_shadow [NSRC];
  logic [31:0] degraded_ms;
  logic [31:0] lost_ms;
  logic [7:0]  misses_needed;
  logic [7:0]  fresh_needed;

  event_t  pending_events [$];
  report_t expected_reports [$];
  event_t  cur_event;
  logic    in_fired = 1'b0;
  int      src_idle_pct = 0;
  int      sink_stall_pct = 0;
  int      errors = 0;
  int      events_taken = 0;
  int      reports_checked = 0;
  int      cfg_writes = 0;
  int      quiet_cycles = 0;
  logic [62:0] sim_now = 63'd5_000_000_000;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Ages one entry at the given time. This is shared by tick, which writes the
  // outcome back, and snapshot, which only reports it.
  function automatic void assess(input int s, input logic [62:0] now,
                                 output logic [1:0] lv, output logic [2:0] rs,
                                 output report_t rep);
    entry_t e;
    longint age_ns;
    longint age_ms;
    e = table_shadow[s];
    lv = e.level;
    rs = e.reason;
    age_ns = 0;
    age_ms = 0;
    if (!e.ever || e.last == '0) begin
      lv = LVL_LOST;
      rs = RSN_NODATA;
    end else begin
      if (now >= e.last) age_ns = longint'({1'b0, now - e.last});
      else age_ns = -longint'({1'b0, e.last - now});
      age_ms = age_ns / 64'sd1000000;
      if (age_ns >= longint'({32'd0, lost_ms}) * 64'sd1000000) begin
        lv = LVL_LOST;
        if (rs != RSN_LEASE && rs != RSN_UNMATCHED) rs = RSN_NODATA;
      end else if (age_ns >= longint'({32'd0, degraded_ms}) * 64'sd1000000 &&
                   lv == LVL_HEALTHY) begin
        lv = LVL_DEGRADED;
        rs = RSN_STALE;
      end
    end
    rep.level = lv;
    rep.reason = rs;
    rep.last = e.last;
    rep.age_ms = age_ms[44:0];
    rep.misses = e.misses;
    rep.leases = e.leases;
    rep.qos = e.qos;
    rep.matched = e.matched;
    rep.known = 1'b1;
  endfunction

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  // Applies one accepted event to the shadow table and queues the report
  // that a tick or a snapshot produces.
  function automatic void apply_event(input event_t ev);
    int s;
    entry_t e;
    report_t rep;
    logic [1:0] lv;
    logic [2:0] rs;
    s = int'(ev.src) % NSRC;
    rep = '{default: '0};
    if (ev.cmd == CMD_UNKNOWN) return;
    if (ev.cmd == CMD_SNAPSHOT) begin
      if (present_shadow[s]) assess(s, ev.now, lv, rs, rep);
      expected_reports.push_back(rep);
      return;
    end
    if (!present_shadow[s]) begin
      present_shadow[s] = 1'b1;
      table_shadow[s] = ENTRY_RESET;
    end
    e = table_shadow[s];
    case (ev.cmd)
      CMD_SAMPLE: begin
        e.last = ev.now;
        e.miss = '0;
        if (ev.age > degraded_ms) begin
          e.fresh = '0;
          e.ever = 1'b1;
          if (e.level == LVL_HEALTHY) e.level = LVL_DEGRADED;
          if (e.level != LVL_LOST) e.reason = RSN_STALE;
        end else begin
          if (e.fresh < fresh_needed) e.fresh = e.fresh + 8'd1;
          if (!e.ever) begin
            e.ever = 1'b1;
            e.level = LVL_HEALTHY;
            e.reason = RSN_NONE;
          end else if (e.level == LVL_HEALTHY) begin
            e.reason = RSN_NONE;
          end else if (e.fresh >= fresh_needed) begin
            e.level = LVL_HEALTHY;
            e.reason = RSN_NONE;
          end else begin
            e.reason = RSN_RECOVERING;
          end
        end
      end
      CMD_MISS: begin
        e.misses = sat_inc(e.misses);
        if (e.miss != 8'd255) e.miss = e.miss + 8'd1;
        e.fresh = '0;
        if (e.miss >= misses_needed && e.level == LVL_HEALTHY) begin
          e.level = LVL_DEGRADED;
          e.reason = RSN_DEADLINE;
        end
      end
      CMD_LEASE: begin
        e.leases = sat_inc(e.leases);
        e.fresh = '0;
        e.level = LVL_LOST;
        e.reason = RSN_LEASE;
      end
      CMD_QOS: begin
        e.qos = sat_inc(e.qos);
        e.level = LVL_DEGRADED;
        e.reason = RSN_QOS;
      end
      CMD_MATCH: begin
        e.matched = ev.matched;
        if (!ev.matched) begin
          e.fresh = '0;
          e.level = LVL_LOST;
          e.reason = RSN_UNMATCHED;
        end
      end
      default: begin
        // Tick: age against the thresholds and keep the outcome.
        table_shadow[s] = e;
        assess(s, ev.now, lv, rs, rep);
        if (lv != e.level) e.fresh = '0;
        e.level = lv;
        e.reason = rs;
        expected_reports.push_back(rep);
      end
    endcase
    table_shadow[s] = e;
  endfunction

  task automatic check_field(input string name, input logic [63:0] exp_v,
                             input logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
      errors++;
    end
  endtask

  // Sender side: a new event is presented at the falling edge once the
  // previous one has been transferred, unless the sender idles this cycle.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || in_fired) begin
        if (pending_events.size() > 0 && $urandom_range(0, 99) >= src_idle_pct) begin
          cur_event = pending_events.pop_front();
          cmd_i = cur_event.cmd;
          source_index_i = cur_event.src;
          now_time_ns_i = cur_event.now;
          sample_age_ms_i = cur_event.age;
          matched_flag_i = cur_event.matched;
          in_valid_i = 1'b1;
        end else begin
          in_valid_i = 1'b0;
        end
      end
      in_fired = 1'b0;
      out_ready_i = ($urandom_range(0, 99) >= sink_stall_pct);
    end
  end

  // Monitor: predicts on every input transfer and checks every result
  // transfer against the oldest expected report.
  always @(posedge clk_i) begin
    report_t exp_r;
    logic activity;
    activity = 1'b0;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        apply_event(cur_event);
        in_fired = 1'b1;
        events_taken++;
        activity = 1'b1;
      end
      if (out_valid_o && out_ready_i) begin
        activity = 1'b1;
        if (expected_reports.size() == 0) begin
          $error("unexpected result transfer");
          errors++;
        end else begin
          exp_r = expected_reports.pop_front();
          check_field("out_level", 64'(exp_r.level), 64'(out_level_o));
          check_field("out_reason", 64'(exp_r.reason), 64'(out_reason_o));
          check_field("out_last_sample_time", 64'(exp_r.last),
                      64'(out_last_sample_time_o));
          check_field("out_age_ms", 64'(exp_r.age_ms), 64'($unsigned(out_age_ms_o)));
          check_field("out_deadline_misses", 64'(exp_r.misses),
                      64'(out_deadline_misses_o));
          check_field("out_lease_losses", 64'(exp_r.leases), 64'(out_lease_losses_o));
          check_field("out_qos_events", 64'(exp_r.qos), 64'(out_qos_events_o));
          check_field("out_writer_matched", 64'(exp_r.matched),
                      64'(out_writer_matched_o));
          check_field("out_source_known", 64'(exp_r.known), 64'(out_source_known_o));
          reports_checked++;
        end
      end
      if (cfg_valid_i && cfg_ready_o) activity = 1'b1;
      quiet_cycles = activity ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("FAIL source_health_tracker");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    @(negedge clk_i);
    cfg_index_i = idx;
    cfg_data_i = val;
    cfg_valid_i = 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_DEGRADED_MS: degraded_ms = val;
      REG_LOST_MS:     lost_ms = val;
      REG_MISSES:      misses_needed = val[7:0];
      default:         fresh_needed = val[7:0];
    endcase
    cfg_writes++;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // Waits until every queued event has gone in and every report has come
  // out, then lets the last event finish in case it made no report.
  task automatic drain();
    do @(posedge clk_i);
    while (pending_events.size() != 0 || in_valid_i || expected_reports.size() != 0);
    repeat (80) @(posedge clk_i);
  endtask

  task automatic push(input cmd_e c, input int s, input logic [62:0] now,
                      input logic [31:0] age, input logic m);
    event_t ev;
    ev.cmd = c;
    ev.src = s[3:0];
    ev.now = now;
    ev.age = age;
    ev.matched = m;
    pending_events.push_back(ev);
  endtask

  // Random event built around the current thresholds. Time mostly moves
  // forward in steps near the thresholds, sometimes back, sometimes wild or zero.
  task automatic push_random(input int hot_src);
    event_t ev;
    int pick;
    longint unsigned span;
    longint unsigned step;
    span = 64'((lost_ms > degraded_ms) ? lost_ms : degraded_ms);
    if (span > 3000) span = 3000;
    pick = $urandom_range(0, 19);
    step = longint'($urandom_range(0, int'(span) + 2)) * 1000000 +
           longint'($urandom_range(0, 999999));
    if (pick < 14) sim_now = sim_now + step[62:0];
    else if (pick < 16) sim_now = sim_now - step[62:0];
    else if (pick == 16) sim_now = 63'({$urandom, $urandom});
    else if (pick == 17) sim_now = '0;
    ev.now = sim_now;
    pick = $urandom_range(0, 99);
    if (pick < 35) ev.cmd = CMD_SAMPLE;
    else if (pick < 55) ev.cmd = CMD_TICK;
    else if (pick < 67) ev.cmd = CMD_SNAPSHOT;
    else if (pick < 79) ev.cmd = CMD_MISS;
    else if (pick < 84) ev.cmd = CMD_LEASE;
    else if (pick < 89) ev.cmd = CMD_QOS;
    else if (pick < 97) ev.cmd = CMD_MATCH;
    else ev.cmd = CMD_UNKNOWN;
    ev.src = ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'(hot_src + $urandom_range(0, 2));
    case ($urandom_range(0, 5))
      0: ev.age = degraded_ms;
      1: ev.age = degraded_ms + 32'd1;
      2: ev.age = $urandom;
      default: ev.age = (degraded_ms == 0) ? 32'd0 : $urandom_range(0, degraded_ms);
    endcase
    ev.matched = ($urandom_range(0, 2) != 0);
    pending_events.push_back(ev);
  endtask

  initial begin
    int phase;
    for (int i = 0; i < NSRC; i++) begin
      table_shadow[i] = ENTRY_RESET;
      present_shadow[i] = 1'b0;
    end
    degraded_ms = 32'd100;
    lost_ms = 32'd1000;
    misses_needed = 8'd2;
    fresh_needed = 8'd3;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part with the reset thresholds and no idling. It covers the
    // untouched entry, a sample at time zero, staleness, recovery, every
    // command, time going backwards, an unknown command and the field limits.
    push(CMD_SNAPSHOT, 9, 63'd1, 32'd0, 1'b0);
    push(CMD_TICK, 10, 63'd1, 32'd0, 1'b0);
    push(CMD_SNAPSHOT, 10, 63'd1, 32'd0, 1'b0);
    push(CMD_SAMPLE, 0, 63'd0, 32'd0, 1'b0);
    push(CMD_TICK, 0, 63'd2_000_000_000, 32'd0, 1'b0);
    push(CMD_SAMPLE, 1, 63'd1_000_000_000, 32'd10, 1'b0);
    push(CMD_TICK, 1, 63'd1_150_000_000, 32'd0, 1'b0);
    push(CMD_SAMPLE, 1, 63'd1_200_000_000, 32'd100, 1'b0);
    push(CMD_SAMPLE, 1, 63'd1_210_000_000, 32'd101, 1'b0);
    push(CMD_SAMPLE, 1, 63'd1_220_000_000, 32'd0, 1'b0);
    push(CMD_SAMPLE, 1, 63'd1_230_000_000, 32'd0, 1'b0);
    push(CMD_SAMPLE, 1, 63'd1_240_000_000, 32'd0, 1'b0);
    push(CMD_MISS, 1, 63'd0, 32'd0, 1'b0);
    push(CMD_MISS, 1, 63'd0, 32'd0, 1'b0);
    push(CMD_TICK, 1, 63'd1_100_000_000, 32'd0, 1'b0);
    push(CMD_LEASE, 2, 63'd0, 32'd0, 1'b0);
    push(CMD_QOS, 1, 63'd0, 32'd0, 1'b0);
    push(CMD_MATCH, 1, 63'd0, 32'd0, 1'b1);
    push(CMD_MATCH, 2, 63'd0, 32'd0, 1'b0);
    push(CMD_TICK, 1, 63'd2_240_000_000, 32'd0, 1'b0);
    push(CMD_SNAPSHOT, 2, 63'd5, 32'd0, 1'b0);
    push(CMD_UNKNOWN, 3, 63'd7, 32'd7, 1'b1);
    push(CMD_SAMPLE, 15, {63{1'b1}}, 32'hFFFF_FFFF, 1'b1);
    push(CMD_SNAPSHOT, 15, 63'd1, 32'd0, 1'b1);
    push(CMD_SNAPSHOT, 15, {63{1'b1}}, 32'hFFFF_FFFF, 1'b1);
    drain();

    // Random phases, each with its own thresholds and one of four idling patterns.
    for (phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin
          write_reg(REG_DEGRADED_MS, 32'd50);
          write_reg(REG_LOST_MS, 32'd400);
          write_reg(REG_MISSES, 32'd1);
          write_reg(REG_FRESH, 32'd1);
        end
        1: begin
          write_reg(REG_DEGRADED_MS, 32'd0);
          write_reg(REG_LOST_MS, 32'd0);
          write_reg(REG_MISSES, 32'd255);
          write_reg(REG_FRESH, 32'd255);
        end
        2: begin
          write_reg(REG_DEGRADED_MS, 32'hFFFF_FFFF);
          write_reg(REG_LOST_MS, 32'hFFFF_FFFF);
          write_reg(REG_MISSES, 32'd3);
          write_reg(REG_FRESH, 32'd2);
        end
        3: begin
          write_reg(REG_DEGRADED_MS, $urandom_range(1, 300));
          write_reg(REG_LOST_MS, degraded_ms + $urandom_range(0, 1500));
          write_reg(REG_MISSES, $urandom_range(1, 4));
          write_reg(REG_FRESH, $urandom_range(1, 4));
        end
        4: begin
          // Lost threshold below the degraded one.
          write_reg(REG_DEGRADED_MS, 32'd200);
          write_reg(REG_LOST_MS, 32'd150);
          write_reg(REG_MISSES, 32'd2);
          write_reg(REG_FRESH, 32'd3);
        end
        default: begin
          write_reg(REG_DEGRADED_MS, 32'd100);
          write_reg(REG_LOST_MS, 32'd1000);
          write_reg(REG_MISSES, 32'd2);
          write_reg(REG_FRESH, 32'd3);
        end
      endcase
      case (phase % 4)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 57; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 57; end
        default: begin src_idle_pct = 36; sink_stall_pct = 36; end
      endcase
      if (phase == 1) begin
        // A long run of deadline misses drives the run counter to its ceiling.
        push(CMD_SAMPLE, 5, sim_now, 32'd0, 1'b1);
        for (int k = 0; k < 260; k++) push(CMD_MISS, 5, sim_now, 32'd0, 1'b0);
        push(CMD_TICK, 5, sim_now, 32'd0, 1'b0);
        for (int k = 0; k < 40; k++) push_random(4 * (k % 4));
      end else begin
        for (int k = 0; k < 65; k++) push_random(4 * ((k / 16) % 4));
      end
      drain();
    end

    $display("Covered %0d event transfers and %0d checked reports", events_taken,
             reports_checked);
    $display("across %0d register writes and four idling patterns.", cfg_writes);
    if (errors == 0) begin
      $display("PASS source_health_tracker");
    end else begin
      $display("FAIL source_health_tracker");
    end
    $finish;
  end

endmodule
